/* sv/acrlp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// AC entry run-length packer package
// Field widths, shared types and word formatting functions.
// ----------------------------------------------------------------------------
package acrlp_pkg;

   localparam int DC_W             = 11;
   localparam int BIN_W            = 22;
   localparam int KEY_IN_W         = 16;
   localparam int WORD_W           = 32;
   localparam int LEN_W            = 6;
   localparam int DELTA_W          = 4;
   localparam int CNT_W            = 5;
   localparam int RUN_CHUNK        = 32;
   localparam int KEY_BITS_DEFAULT = 16;
   localparam int MAX_WORDS        = 3;
   localparam int REM_W            = 2;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [DC_W-1:0]     dc_first;
      logic [DC_W-1:0]     dc_second;
      logic [DC_W-1:0]     dc_third;
      logic [BIN_W-1:0]    bin_id;
      logic [KEY_IN_W-1:0] histo_key;
      logic [KEY_IN_W-1:0] ctx_key;
      logic                pass_start;
      logic                group_end;
   } item_type;

   typedef struct packed {
      logic [REM_W-1:0]               count;
      word_type [MAX_WORDS-1:0]       words;
   } burst_type;

   typedef struct packed {
      logic             run_active;
      logic             at_group_start;
      logic [LEN_W-1:0] run_len;
   } run_status_type;

   function automatic word_type make_run_word(input logic [DC_W-1:0]    b,
                                              input logic [DC_W-1:0]    c,
                                              input logic [DELTA_W-1:0] delta,
                                              input logic               continued,
                                              input logic [CNT_W-1:0]   cnt);
      return {1'b0, (continued ? {DELTA_W{1'b0}} : delta), b, c, cnt};
   endfunction

   function automatic word_type make_marker(input logic             ctx_chg,
                                            input logic             hist_chg,
                                            input logic [BIN_W-1:0] bin,
                                            input logic [DC_W-1:0]  a);
      return {1'b1, ctx_chg, hist_chg, bin, a[DC_W-1:DELTA_W]};
   endfunction

endpackage
`default_nettype wire

/* sv/acrlp_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// AC entry request channel
// Valid/ready channel that carries one ordered AC entry per transfer.
// ----------------------------------------------------------------------------
interface acrlp_req_if;
   logic                               valid;
   logic                               ready;
   logic [acrlp_pkg::DC_W-1:0]         dc_first;
   logic [acrlp_pkg::DC_W-1:0]         dc_second;
   logic [acrlp_pkg::DC_W-1:0]         dc_third;
   logic [acrlp_pkg::BIN_W-1:0]        bin_id;
   logic [acrlp_pkg::KEY_IN_W-1:0]     histo_key;
   logic [acrlp_pkg::KEY_IN_W-1:0]     ctx_key;
   logic                               pass_start;
   logic                               group_end;

   modport source (output valid, dc_first, dc_second, dc_third, bin_id, histo_key, ctx_key,
                   pass_start, group_end, input ready);
   modport sink   (input valid, dc_first, dc_second, dc_third, bin_id, histo_key, ctx_key,
                   pass_start, group_end, output ready);
endinterface
`default_nettype wire

/* sv/acrlp_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Packed word response channel
// Valid/ready channel that carries one stream word per transfer.
// ----------------------------------------------------------------------------
interface acrlp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [acrlp_pkg::WORD_W-1:0]  word;
   logic                          last_of_item;

   modport source (output valid, word, last_of_item, input ready);
   modport sink   (input valid, word, last_of_item, output ready);
endinterface
`default_nettype wire

/* sv/acrlp_in_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted entry until the packing logic consumes it.
// ----------------------------------------------------------------------------
module acrlp_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   acrlp_req_if.sink               req_chan,
   input  wire logic               fire,
   output acrlp_pkg::item_type     item,
   output logic                    item_valid
);

   logic                valid_ff;
   logic                valid_in;
   acrlp_pkg::item_type item_ff;
   logic                take;

   assign req_chan.ready = ~valid_ff | fire;
   assign take           = req_chan.valid & req_chan.ready;
   assign valid_in       = take | (valid_ff & ~fire);
   assign item           = item_ff;
   assign item_valid     = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{dc_first:   req_chan.dc_first,
                      dc_second:  req_chan.dc_second,
                      dc_third:   req_chan.dc_third,
                      bin_id:     req_chan.bin_id,
                      histo_key:  req_chan.histo_key,
                      ctx_key:    req_chan.ctx_key,
                      pass_start: req_chan.pass_start,
                      group_end:  req_chan.group_end};
      end
   end

endmodule
`default_nettype wire

/* sv/acrlp_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Run merge and word formation
// Keeps the open run, base and group keys, and forms up to three words for
// each entry in a single pass.
// ----------------------------------------------------------------------------
module acrlp_core #(
   parameter int KEY_BITS = acrlp_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     item_valid,
   input  wire acrlp_pkg::item_type      item,
   input  wire logic                     load_ok,
   output logic                          fire,
   output acrlp_pkg::burst_type          burst,
   output acrlp_pkg::run_status_type     status
);

   localparam int KEY_W = (KEY_BITS < acrlp_pkg::KEY_IN_W) ? KEY_BITS : acrlp_pkg::KEY_IN_W;
   localparam int DC_W  = acrlp_pkg::DC_W;
   localparam int DL_W  = acrlp_pkg::DELTA_W;
   localparam int LEN_W = acrlp_pkg::LEN_W;
   localparam int CNT_W = acrlp_pkg::CNT_W;

   logic             run_active_ff, run_active_in;
   logic [DC_W-1:0]  run_a_ff, run_a_in;
   logic [DC_W-1:0]  run_b_ff, run_b_in;
   logic [DC_W-1:0]  run_c_ff, run_c_in;
   logic [LEN_W-1:0] run_len_ff, run_len_in;
   logic [DL_W-1:0]  run_delta_ff, run_delta_in;
   logic             run_cont_ff, run_cont_in;
   logic [DC_W-1:0]  base_ff, base_in;
   logic             group_start_ff, group_start_in;
   logic             prev_valid_ff, prev_valid_in;
   logic [KEY_W-1:0] prev_hist_ff, prev_hist_in;
   logic [KEY_W-1:0] prev_ctx_ff, prev_ctx_in;

   logic             act1, gs1, pv1, same, merge, chunk_full, cont, jump, mark;
   logic             hist_chg, ctx_chg, e0, e1, e2;
   logic [DC_W-1:0]  base1;
   logic [DC_W:0]    base_diff;
   logic [LEN_W-1:0] len_m1, len_nx, len_nx_m1;
   logic [DC_W-1:0]  a_nx, b_nx, c_nx;
   logic [DL_W-1:0]  delta_nx;
   logic             cont_nx;
   acrlp_pkg::word_type flush_word, cont_word, mark_word, mid_word, end_word;

   always_comb begin
      act1       = run_active_ff & ~item.pass_start;
      gs1        = group_start_ff | item.pass_start;
      pv1        = prev_valid_ff & ~item.pass_start;
      base1      = item.pass_start ? '0 : base_ff;
      same       = (item.dc_first == run_a_ff) && (item.dc_second == run_b_ff) &&
                   (item.dc_third == run_c_ff);
      merge      = act1 & ~gs1 & same;
      chunk_full = run_len_ff >= LEN_W'(acrlp_pkg::RUN_CHUNK);
      cont       = merge & chunk_full;
      len_m1     = run_len_ff - LEN_W'(1);
      base_diff  = {1'b0, item.dc_first} - {1'b0, base1};
      jump       = base_diff[DC_W] | (|base_diff[DC_W-1:DL_W]);
      mark       = ~merge & (gs1 | jump);
      hist_chg   = gs1 & pv1 & (item.histo_key[KEY_W-1:0] != prev_hist_ff);
      ctx_chg    = gs1 & pv1 & (item.ctx_key[KEY_W-1:0] != prev_ctx_ff);

      flush_word = acrlp_pkg::make_run_word(run_b_ff, run_c_ff, run_delta_ff, run_cont_ff,
                                            len_m1[CNT_W-1:0]);
      cont_word  = acrlp_pkg::make_run_word(run_b_ff, run_c_ff, run_delta_ff, run_cont_ff,
                                            CNT_W'(acrlp_pkg::RUN_CHUNK - 1));
      mark_word  = acrlp_pkg::make_marker(ctx_chg, hist_chg, item.bin_id, item.dc_first);
      mid_word   = cont ? cont_word : mark_word;

      if (merge) begin
         a_nx     = run_a_ff;
         b_nx     = run_b_ff;
         c_nx     = run_c_ff;
         len_nx   = cont ? LEN_W'(1) : run_len_ff + LEN_W'(1);
         delta_nx = run_delta_ff;
         cont_nx  = run_cont_ff | cont;
      end else begin
         a_nx     = item.dc_first;
         b_nx     = item.dc_second;
         c_nx     = item.dc_third;
         len_nx   = LEN_W'(1);
         delta_nx = mark ? item.dc_first[DL_W-1:0] : base_diff[DL_W-1:0];
         cont_nx  = 1'b0;
      end
      len_nx_m1 = len_nx - LEN_W'(1);
      end_word  = acrlp_pkg::make_run_word(b_nx, c_nx, delta_nx, cont_nx,
                                           len_nx_m1[CNT_W-1:0]);

      e0 = run_active_ff & (item.pass_start | ~merge);
      e1 = cont | mark;
      e2 = item.group_end;

      burst.count    = acrlp_pkg::REM_W'({1'b0, e0} + {1'b0, e1} + {1'b0, e2});
      burst.words[0] = e0 ? flush_word : (e1 ? mid_word : end_word);
      burst.words[1] = e0 ? (e1 ? mid_word : end_word) : end_word;
      burst.words[2] = end_word;

      fire = item_valid & load_ok;

      run_active_in  = run_active_ff;
      run_a_in       = run_a_ff;
      run_b_in       = run_b_ff;
      run_c_in       = run_c_ff;
      run_len_in     = run_len_ff;
      run_delta_in   = run_delta_ff;
      run_cont_in    = run_cont_ff;
      base_in        = base_ff;
      group_start_in = group_start_ff;
      prev_valid_in  = prev_valid_ff;
      prev_hist_in   = prev_hist_ff;
      prev_ctx_in    = prev_ctx_ff;
      if (fire) begin
         run_active_in  = ~item.group_end;
         run_a_in       = a_nx;
         run_b_in       = b_nx;
         run_c_in       = c_nx;
         run_len_in     = item.group_end ? '0 : len_nx;
         run_delta_in   = delta_nx;
         run_cont_in    = ~item.group_end & cont_nx;
         base_in        = merge ? base1 : item.dc_first;
         group_start_in = item.group_end;
         prev_valid_in  = pv1 | (gs1 & ~merge);
         if (gs1 & ~merge) begin
            prev_hist_in = item.histo_key[KEY_W-1:0];
            prev_ctx_in  = item.ctx_key[KEY_W-1:0];
         end
      end
   end

   assign status = '{run_active: run_active_ff, at_group_start: group_start_ff,
                     run_len: run_len_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff  <= 1'b0;
         run_a_ff       <= '0;
         run_b_ff       <= '0;
         run_c_ff       <= '0;
         run_len_ff     <= '0;
         run_delta_ff   <= '0;
         run_cont_ff    <= 1'b0;
         base_ff        <= '0;
         group_start_ff <= 1'b1;
         prev_valid_ff  <= 1'b0;
         prev_hist_ff   <= '0;
         prev_ctx_ff    <= '0;
      end else begin
         run_active_ff  <= run_active_in;
         run_a_ff       <= run_a_in;
         run_b_ff       <= run_b_in;
         run_c_ff       <= run_c_in;
         run_len_ff     <= run_len_in;
         run_delta_ff   <= run_delta_in;
         run_cont_ff    <= run_cont_in;
         base_ff        <= base_in;
         group_start_ff <= group_start_in;
         prev_valid_ff  <= prev_valid_in;
         prev_hist_ff   <= prev_hist_in;
         prev_ctx_ff    <= prev_ctx_in;
      end
   end

endmodule
`default_nettype wire

/* sv/acrlp_out_buf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Result word buffer
// Holds the words of one entry and hands them out one per transfer.
// ----------------------------------------------------------------------------
module acrlp_out_buf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire acrlp_pkg::burst_type  burst,
   output logic                       load_ok,
   acrlp_rsp_if.source                rsp_chan
);

   localparam int REM_W = acrlp_pkg::REM_W;

   logic [REM_W-1:0]                          rem_ff, rem_in;
   acrlp_pkg::word_type [acrlp_pkg::MAX_WORDS-1:0] words_ff, words_in;
   logic                                      pop;

   assign rsp_chan.valid        = rem_ff != '0;
   assign rsp_chan.word         = words_ff[0];
   assign rsp_chan.last_of_item = rem_ff == REM_W'(1);
   assign pop                   = rsp_chan.valid & rsp_chan.ready;
   assign load_ok               = (rem_ff == '0) | ((rem_ff == REM_W'(1)) & rsp_chan.ready);

   always_comb begin
      rem_in   = rem_ff;
      words_in = words_ff;
      if (load) begin
         rem_in   = burst.count;
         words_in = burst.words;
      end else if (pop) begin
         rem_in      = rem_ff - REM_W'(1);
         words_in[0] = words_ff[1];
         words_in[1] = words_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

endmodule
`default_nettype wire

/* sv/ac_entry_run_length_packer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// AC entry run-length packer
// Path: an entry passes the input register and the result buffer before its
// first word is offered. Throughput: one entry per cycle while entries give
// at most one word each and the output is ready; an entry with more words
// (up to three) waits while the result buffer sends one word per ready cycle.
// Reset: run closed, group start set, keys and base cleared, buffers empty.
// ----------------------------------------------------------------------------
module ac_entry_run_length_packer #(
   parameter int KEY_BITS = acrlp_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   acrlp_req_if.sink   req_chan,
   acrlp_rsp_if.source rsp_chan
);

   acrlp_pkg::item_type       item;
   logic                      item_valid;
   logic                      fire;
   logic                      load_ok;
   acrlp_pkg::burst_type      burst;
   acrlp_pkg::run_status_type status;

   acrlp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .fire       (fire),
      .item       (item),
      .item_valid (item_valid)
   );

   acrlp_core #(
      .KEY_BITS (KEY_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .load_ok    (load_ok),
      .fire       (fire),
      .burst      (burst),
      .status     (status)
   );

   acrlp_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (fire),
      .burst    (burst),
      .load_ok  (load_ok),
      .rsp_chan (rsp_chan)
   );

   // A group end closes the run and arms the next group.
   a_group_end_closes: assert property (@(posedge clock) disable iff (reset)
      (fire && item.group_end) |=> (status.at_group_start && !status.run_active))
      else $error("run still open after group end");

   a_run_len_range: assert property (@(posedge clock) disable iff (reset)
      status.run_active |-> ((status.run_len != '0) &&
                             (status.run_len <= acrlp_pkg::LEN_W'(acrlp_pkg::RUN_CHUNK))))
      else $error("open run length out of range");

   // Three words need a flush, a marker and a group end flush.
   a_three_words_need_end: assert property (@(posedge clock) disable iff (reset)
      (fire && (burst.count == acrlp_pkg::REM_W'(acrlp_pkg::MAX_WORDS))) |-> item.group_end)
      else $error("three words without group end");

endmodule
`default_nettype wire

/* verif/ac_entry_run_length_packer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AC entry run-length packer testbench
// Sends ordered AC entries through the request channel and predicts the
// packed stream, covering markers, run words, continuation words, base jumps,
// key change flags and pass restarts. Every word received is compared with
// the oldest predicted word. Both channels stall at random until the last
// phase, which runs at full rate.
// ----------------------------------------------------------------------------
module ac_entry_run_length_packer_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int BASE_SPAN    = 15;
   localparam int REPORT_LIMIT = 10;
   localparam int DC_W         = acrlp_pkg::DC_W;
   localparam int BIN_W        = acrlp_pkg::BIN_W;
   localparam int KEY_IN_W     = acrlp_pkg::KEY_IN_W;
   localparam int LEN_W        = acrlp_pkg::LEN_W;
   localparam int DELTA_W      = acrlp_pkg::DELTA_W;
   localparam int CNT_W        = acrlp_pkg::CNT_W;
   localparam int RUN_CHUNK    = acrlp_pkg::RUN_CHUNK;

   typedef struct packed {
      acrlp_pkg::word_type word;
      logic                last;
   } stream_word_type;

   logic clock = 1'b0;
   logic reset;

   acrlp_req_if req_chan ();
   acrlp_rsp_if rsp_chan ();

   ac_entry_run_length_packer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   stream_word_type     pending_words[$];
   acrlp_pkg::word_type entry_words[$];
   int                  mismatch_count = 0;
   int                  items_sent     = 0;
   int                  cycle_count    = 0;
   logic                steady_phase   = 1'b0;

   // Packer state as seen from the stream.
   logic              run_open;
   logic [DC_W-1:0]   run_first, run_second, run_third;
   logic [LEN_W-1:0]  run_count;
   logic [DELTA_W-1:0] run_offset;
   logic              run_split;
   logic [DC_W-1:0]   dc_base;
   logic              group_open;
   logic              keys_known;
   logic [KEY_IN_W-1:0] last_hist;
   logic [KEY_IN_W-1:0] last_ctx;

   initial begin
      run_open   = 1'b0;
      run_first  = '0;
      run_second = '0;
      run_third  = '0;
      run_count  = '0;
      run_offset = '0;
      run_split  = 1'b0;
      dc_base    = '0;
      group_open = 1'b1;
      keys_known = 1'b0;
      last_hist  = '0;
      last_ctx   = '0;
   end

   function automatic acrlp_pkg::word_type run_word(input logic [CNT_W-1:0] cnt);
      return {1'b0, (run_split ? {DELTA_W{1'b0}} : run_offset), run_second, run_third, cnt};
   endfunction

   function automatic void close_run();
      if (run_open) begin
         entry_words.insert(entry_words.size(), run_word(CNT_W'(run_count - 1)));
         run_open  = 1'b0;
         run_count = '0;
         run_split = 1'b0;
      end
   endfunction

   function automatic void pack_entry(input acrlp_pkg::item_type e);
      logic             first;
      logic             ctx_flag;
      logic             hist_flag;
      stream_word_type  sw;
      entry_words.delete();
      if (e.pass_start) begin
         close_run();
         keys_known = 1'b0;
         dc_base    = '0;
         group_open = 1'b1;
      end
      if (run_open && !group_open && e.dc_first == run_first && e.dc_second == run_second
          && e.dc_third == run_third) begin
         if (run_count >= RUN_CHUNK) begin
            entry_words.insert(entry_words.size(), run_word(CNT_W'(RUN_CHUNK - 1)));
            run_split = 1'b1;
            run_count = LEN_W'(1);
         end else begin
            run_count = LEN_W'(run_count + 1);
         end
      end else begin
         first = group_open;
         close_run();
         if (first || e.dc_first < dc_base || int'(e.dc_first - dc_base) > BASE_SPAN) begin
            ctx_flag  = first && keys_known && (e.ctx_key != last_ctx);
            hist_flag = first && keys_known && (e.histo_key != last_hist);
            entry_words.insert(entry_words.size(), {1'b1, ctx_flag, hist_flag, e.bin_id,
                                                    e.dc_first[DC_W-1:DELTA_W]});
            dc_base = {e.dc_first[DC_W-1:DELTA_W], {DELTA_W{1'b0}}};
         end
         run_offset = DELTA_W'(e.dc_first - dc_base);
         dc_base    = e.dc_first;
         run_first  = e.dc_first;
         run_second = e.dc_second;
         run_third  = e.dc_third;
         run_count  = LEN_W'(1);
         run_split  = 1'b0;
         run_open   = 1'b1;
         if (first) begin
            keys_known = 1'b1;
            last_hist  = e.histo_key;
            last_ctx   = e.ctx_key;
         end
         group_open = 1'b0;
      end
      if (e.group_end) begin
         close_run();
         group_open = 1'b1;
      end
      for (int i = 0; i < entry_words.size(); i++) begin
         sw.word = entry_words[i];
         sw.last = (i == entry_words.size() - 1);
         pending_words.insert(pending_words.size(), sw);
      end
   endfunction

   function automatic acrlp_pkg::item_type make_entry(input int a, input int b, input int c,
                                                      input int bin, input int hist,
                                                      input int ctx, input int ps,
                                                      input int ge);
      acrlp_pkg::item_type e;
      e.dc_first   = DC_W'(a);
      e.dc_second  = DC_W'(b);
      e.dc_third   = DC_W'(c);
      e.bin_id     = BIN_W'(bin);
      e.histo_key  = KEY_IN_W'(hist);
      e.ctx_key    = KEY_IN_W'(ctx);
      e.pass_start = ps[0];
      e.group_end  = ge[0];
      return e;
   endfunction

   task automatic send_entry(input acrlp_pkg::item_type e);
      if (!steady_phase && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.dc_first   <= e.dc_first;
      req_chan.dc_second  <= e.dc_second;
      req_chan.dc_third   <= e.dc_third;
      req_chan.bin_id     <= e.bin_id;
      req_chan.histo_key  <= e.histo_key;
      req_chan.ctx_key    <= e.ctx_key;
      req_chan.pass_start <= e.pass_start;
      req_chan.group_end  <= e.group_end;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pack_entry(e);
      items_sent++;
   endtask

   task automatic note_mismatch(input string what, input acrlp_pkg::word_type want,
                                input acrlp_pkg::word_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("Mismatch on %s: expected %h, got %h", what, want, got);
   endtask

   always @(posedge clock) begin : check_words
      stream_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_words.size() == 0) begin
            note_mismatch("unexpected word", '0, rsp_chan.word);
         end else begin
            want = pending_words.pop_front();
            if (rsp_chan.word !== want.word)
               note_mismatch("word", want.word, rsp_chan.word);
            if (rsp_chan.last_of_item !== want.last)
               note_mismatch("last_of_item", acrlp_pkg::word_type'(want.last),
                             acrlp_pkg::word_type'(rsp_chan.last_of_item));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && !steady_phase && $urandom_range(0, 7) == 0) begin
         rsp_chan.ready <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[ac_entry_run_length_packer] ERROR");
         $finish;
      end
   end

   task automatic test_field_extremes();
      send_entry(make_entry(0, 0, 0, 0, 0, 0, 1, 1));
      send_entry(make_entry(2047, 2047, 2047, 'h3FFFFF, 'hFFFF, 'hFFFF, 0, 1));
      send_entry(make_entry(2047, 0, 2047, 'h2AAAAA, 'hFFFF, 'h0000, 0, 1));
      send_entry(make_entry(1, 2, 3, 'h155555, 'h0000, 'h0000, 1, 1));
   endtask

   task automatic test_base_jumps();
      send_entry(make_entry(100, 5, 6, 'h012345, 'h1234, 'h4321, 0, 0));
      send_entry(make_entry(110, 5, 6, 'h012345, 'h1234, 'h4321, 0, 0));
      send_entry(make_entry(126, 5, 6, 'h012345, 'h1234, 'h4321, 0, 0));
      send_entry(make_entry(120, 5, 6, 'h012345, 'h1234, 'h4321, 0, 0));
      send_entry(make_entry(135, 5, 6, 'h012345, 'h1234, 'h4321, 0, 0));
      send_entry(make_entry(150, 5, 6, 'h012345, 'h1234, 'h4321, 0, 1));
   endtask

   task automatic test_pass_restart();
      send_entry(make_entry(500, 1, 2, 'h0ABCDE, 1, 2, 0, 1));
      send_entry(make_entry(500, 1, 2, 'h0ABCDE, 1, 2, 0, 0));
      send_entry(make_entry(500, 1, 2, 'h0ABCDE, 1, 2, 1, 0));
      send_entry(make_entry(500, 1, 2, 'h0ABCDE, 1, 2, 1, 1));
      send_entry(make_entry(700, 9, 9, 'h3C3C3C, 7, 8, 0, 1));
   endtask

   task automatic test_short_merge();
      send_entry(make_entry(7, 2047, 0, 'h000FFF, 3, 3, 0, 0));
      send_entry(make_entry(7, 2047, 0, 'h000FFF, 3, 3, 0, 0));
      send_entry(make_entry(7, 2047, 0, 'h000FFF, 3, 3, 0, 0));
      send_entry(make_entry(7, 2047, 0, 'h000FFF, 3, 3, 0, 1));
   endtask

   task automatic test_long_runs();
      acrlp_pkg::item_type e;
      int                  run_lengths[3];
      int                  r, k;
      run_lengths[0] = RUN_CHUNK;
      run_lengths[1] = RUN_CHUNK + 1;
      run_lengths[2] = 2 * RUN_CHUNK + 1;
      e = make_entry($urandom_range(0, 2047), 0, $urandom_range(0, 2047), $urandom,
                     $urandom, $urandom, 0, 0);
      for (r = 0; r < 3; r++) begin
         e.dc_second = DC_W'(r);
         for (k = 0; k < run_lengths[r]; k++) begin
            e.group_end = (r == 2) && (k == run_lengths[r] - 1);
            send_entry(e);
         end
      end
   endtask

   task automatic test_random_groups(input int n_items);
      acrlp_pkg::item_type e;
      int                  stop_at, runs, reps, r, k;
      logic                closes;
      logic [DC_W-1:0]     a;
      logic [KEY_IN_W-1:0] hist, ctx;
      stop_at = items_sent + n_items;
      hist = KEY_IN_W'($urandom);
      ctx  = KEY_IN_W'($urandom);
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            e = make_entry($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(0, 1), $urandom_range(0, 1));
            send_entry(e);
         end else begin
            if ($urandom_range(0, 2) == 0) hist = KEY_IN_W'($urandom);
            if ($urandom_range(0, 2) == 0) ctx = KEY_IN_W'($urandom);
            a      = DC_W'($urandom);
            runs   = $urandom_range(1, 6);
            closes = ($urandom_range(0, 7) != 0);
            e = make_entry(0, 0, 0, $urandom, int'(hist), int'(ctx),
                           int'($urandom_range(0, 5) == 0), 0);
            for (r = 0; r < runs; r++) begin
               case ($urandom_range(0, 5))
                  0: a = a - DC_W'($urandom_range(1, 40));
                  1: a = a + DC_W'($urandom_range(16, 300));
                  default: a = a + DC_W'($urandom_range(0, 15));
               endcase
               e.dc_first  = a;
               e.dc_second = DC_W'($urandom);
               e.dc_third  = DC_W'($urandom);
               reps = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 70)
                                                   : $urandom_range(1, 4);
               for (k = 0; k < reps; k++) begin
                  e.group_end = closes && (r == runs - 1) && (k == reps - 1);
                  send_entry(e);
                  e.pass_start = 1'b0;
               end
            end
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.dc_first   <= '0;
      req_chan.dc_second  <= '0;
      req_chan.dc_third   <= '0;
      req_chan.bin_id     <= '0;
      req_chan.histo_key  <= '0;
      req_chan.ctx_key    <= '0;
      req_chan.pass_start <= 1'b0;
      req_chan.group_end  <= 1'b0;
      rsp_chan.ready      <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_base_jumps();
      test_pass_restart();
      test_short_merge();
      test_long_runs();
      test_random_groups(230);
      steady_phase = 1'b1;
      test_random_groups(60);
      req_chan.valid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ac_entry_run_length_packer] OK");
      else
         $display("[ac_entry_run_length_packer] ERROR");
      $finish;
   end

endmodule
